// File: hw/rtl/dbm_pkg.sv
// Package with the command codes and controller states of the dominance matching block.
package dbm_pkg;

   localparam logic [1:0] CMD_LOAD_RED  = 2'd0;
   localparam logic [1:0] CMD_LOAD_BLUE = 2'd1;
   localparam logic [1:0] CMD_COMPUTE   = 2'd2;
   localparam logic [1:0] CMD_RESERVED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_LOADU,
      ST_SCAN,
      ST_CMP,
      ST_POP,
      ST_AUGWR,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/dominance_bipartite_matching.sv
// Dominance bipartite matching: point stores, augmenting-path search controller and result.
//
// Red and blue points are loaded into on-chip memories one per cycle while the block is idle;
// a red point can pair with a blue point when both of its coordinates are strictly smaller. A
// compute transfer starts a maximum matching run of depth-first augmenting-path searches, one
// from each of the first point_count red points (at most MAX_POINTS), and returns the pair
// count as one result transfer. A compute runs for as long as the search controller takes:
// each blue candidate that is tested against the current red point is first read from the
// blue and partner memories and then compared, candidates already visited are skipped, the
// search stack is pushed and popped, and each pair on the path is rewritten while augmenting.
// No input transfer is taken while a compute runs.
module dominance_bipartite_matching #(
   parameter int MAX_POINTS = 128,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [6:0]  req_point_index,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pair_count
);
   import dbm_pkg::*;

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1) + 1;
   localparam int CB = COORD_BITS;

   typedef struct packed {
      logic [IW-1:0] red;
      logic [IW-1:0] blue;
   } stack_entry_type;

   // Point memories hold {x, y}.
   logic [2*CB-1:0]  red_mem   [MAX_POINTS];
   logic [2*CB-1:0]  blue_mem  [MAX_POINTS];
   logic [IW-1:0]    partner_mem [MAX_POINTS];
   stack_entry_type  stack_mem [MAX_POINTS];

   logic [2*CB-1:0]  red_rd_ff, blue_rd_ff;
   logic [IW-1:0]    partner_rd_ff;
   stack_entry_type  stack_rd_ff;

   state_type        state_ff, state_in;
   logic [7:0]       point_count_ff;
   logic [MAX_POINTS-1:0] visited_ff, visited_in;
   logic [MAX_POINTS-1:0] pvalid_ff, pvalid_in;
   logic [CW-1:0]    root_ff, root_in;
   logic [CW-1:0]    depth_ff, depth_in;
   logic [CW-1:0]    scan_j_ff, scan_j_in;
   logic [IW-1:0]    top_u_ff, top_u_in;
   logic [CW-1:0]    aug_k_ff, aug_k_in;
   logic [7:0]       count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_pair_count_ff, rsp_pair_count_in;

   logic             load_fire;
   logic             red_rd_en, blue_rd_en, stack_rd_en, stack_wr_en, partner_wr_en;
   logic [IW-1:0]    stack_rd_addr, stack_wr_addr, partner_wr_addr, partner_wr_data;
   stack_entry_type  stack_wr_data;
   logic [CW-1:0]    n_used;
   logic [IW-1:0]    j_idx;
   logic             dominates;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_pair_count_ff;

   assign load_fire = req_valid && req_ready && (int'(req_point_index) < MAX_POINTS);
   assign n_used    = (int'(point_count_ff) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                          : CW'(point_count_ff);
   assign j_idx     = scan_j_ff[IW-1:0];
   assign dominates = (red_rd_ff[2*CB-1:CB] < blue_rd_ff[2*CB-1:CB]) &&
                      (red_rd_ff[CB-1:0]    < blue_rd_ff[CB-1:0]);

   always_ff @(posedge clock) begin
      if (load_fire && req_cmd == CMD_LOAD_RED) begin
         red_mem[IW'(req_point_index)] <= {CB'(req_coord_x), CB'(req_coord_y)};
      end
      if (load_fire && req_cmd == CMD_LOAD_BLUE) begin
         blue_mem[IW'(req_point_index)] <= {CB'(req_coord_x), CB'(req_coord_y)};
      end
      if (red_rd_en) begin
         red_rd_ff <= red_mem[top_u_in];
      end
      if (blue_rd_en) begin
         blue_rd_ff    <= blue_mem[j_idx];
         partner_rd_ff <= partner_mem[j_idx];
      end
      if (partner_wr_en) begin
         partner_mem[partner_wr_addr] <= partner_wr_data;
      end
      if (stack_wr_en) begin
         stack_mem[stack_wr_addr] <= stack_wr_data;
      end
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         point_count_ff    <= '0;
         visited_ff        <= '0;
         pvalid_ff         <= '0;
         root_ff           <= '0;
         depth_ff          <= '0;
         scan_j_ff         <= '0;
         top_u_ff          <= '0;
         aug_k_ff          <= '0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_pair_count_ff <= '0;
      end else begin
         state_ff          <= state_in;
         if (csr_write_enable) begin
            point_count_ff <= csr_write_data;
         end
         visited_ff        <= visited_in;
         pvalid_ff         <= pvalid_in;
         root_ff           <= root_in;
         depth_ff          <= depth_in;
         scan_j_ff         <= scan_j_in;
         top_u_ff          <= top_u_in;
         aug_k_ff          <= aug_k_in;
         count_ff          <= count_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_pair_count_ff <= rsp_pair_count_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      visited_in        = visited_ff;
      pvalid_in         = pvalid_ff;
      root_in           = root_ff;
      depth_in          = depth_ff;
      scan_j_in         = scan_j_ff;
      top_u_in          = top_u_ff;
      aug_k_in          = aug_k_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_pair_count_in = rsp_pair_count_ff;
      red_rd_en         = 1'b0;
      blue_rd_en        = 1'b0;
      stack_rd_en       = 1'b0;
      stack_wr_en       = 1'b0;
      partner_wr_en     = 1'b0;
      stack_rd_addr     = '0;
      stack_wr_addr     = '0;
      stack_wr_data     = '0;
      partner_wr_addr   = '0;
      partner_wr_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd == CMD_COMPUTE) begin
               pvalid_in = '0;
               root_in   = '0;
               count_in  = '0;
               state_in  = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_ff >= n_used) begin
               state_in = ST_DONE;
            end else begin
               visited_in = '0;
               top_u_in   = root_ff[IW-1:0];
               scan_j_in  = '0;
               depth_in   = CW'(1);
               state_in   = ST_LOADU;
            end
         end
         ST_LOADU: begin
            red_rd_en = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_j_ff >= n_used) begin
               depth_in = depth_ff - CW'(1);
               if (depth_ff == CW'(1)) begin
                  root_in  = root_ff + CW'(1);
                  state_in = ST_ROOT;
               end else begin
                  stack_rd_en   = 1'b1;
                  stack_rd_addr = IW'(depth_ff - CW'(2));
                  state_in      = ST_POP;
               end
            end else if (visited_ff[j_idx]) begin
               scan_j_in = scan_j_ff + CW'(1);
            end else begin
               blue_rd_en = 1'b1;
               state_in   = ST_CMP;
            end
         end
         ST_CMP: begin
            if (!dominates) begin
               scan_j_in = scan_j_ff + CW'(1);
               state_in  = ST_SCAN;
            end else begin
               visited_in[j_idx] = 1'b1;
               if (!pvalid_ff[j_idx]) begin
                  // Free blue point: flip the whole path, top level first.
                  partner_wr_en    = 1'b1;
                  partner_wr_addr  = j_idx;
                  partner_wr_data  = top_u_ff;
                  pvalid_in[j_idx] = 1'b1;
                  if (depth_ff == CW'(1)) begin
                     if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
                     root_in  = root_ff + CW'(1);
                     state_in = ST_ROOT;
                  end else begin
                     aug_k_in      = depth_ff - CW'(2);
                     stack_rd_en   = 1'b1;
                     stack_rd_addr = IW'(depth_ff - CW'(2));
                     state_in      = ST_AUGWR;
                  end
               end else if (int'(depth_ff) < MAX_POINTS) begin
                  stack_wr_en        = 1'b1;
                  stack_wr_addr      = IW'(depth_ff - CW'(1));
                  stack_wr_data.red  = top_u_ff;
                  stack_wr_data.blue = j_idx;
                  top_u_in           = partner_rd_ff;
                  scan_j_in          = '0;
                  depth_in           = depth_ff + CW'(1);
                  state_in           = ST_LOADU;
               end else begin
                  scan_j_in = scan_j_ff + CW'(1);
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_POP: begin
            top_u_in  = stack_rd_ff.red;
            scan_j_in = CW'(stack_rd_ff.blue) + CW'(1);
            state_in  = ST_LOADU;
         end
         ST_AUGWR: begin
            partner_wr_en                 = 1'b1;
            partner_wr_addr               = stack_rd_ff.blue;
            partner_wr_data               = stack_rd_ff.red;
            pvalid_in[stack_rd_ff.blue]   = 1'b1;
            if (aug_k_ff == '0) begin
               if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
               root_in  = root_ff + CW'(1);
               state_in = ST_ROOT;
            end else begin
               aug_k_in      = aug_k_ff - CW'(1);
               stack_rd_en   = 1'b1;
               stack_rd_addr = IW'(aug_k_ff - CW'(1));
            end
         end
         ST_DONE: begin
            // The result register may still hold an earlier count until its transfer.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_pair_count_in = count_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: tb/dominance_bipartite_matching_test.sv
// Self-checking testbench for the dominance bipartite matching block.
`timescale 1ns / 1ps

module dominance_bipartite_matching_test;
   import dbm_pkg::*;

   localparam int SLOTS = 128;
   localparam int QUIET_FROM = 3000;
   localparam int QUIET_TO = 9000;
   localparam int STALL_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 20000000;

   typedef struct {
      logic [1:0]  cmd;
      logic [6:0]  slot;
      logic [15:0] x;
      logic [15:0] y;
   } point_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = 2'd0;
   logic [6:0]  req_point_index = 7'd0;
   logic [15:0] req_coord_x = 16'd0;
   logic [15:0] req_coord_y = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_pair_count;

   dominance_bipartite_matching dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_point_index  (req_point_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pair_count   (rsp_pair_count)
   );

   // Predictor state.
   logic [15:0] red_x [SLOTS];
   logic [15:0] red_y [SLOTS];
   logic [15:0] blue_x [SLOTS];
   logic [15:0] blue_y [SLOTS];
   logic [7:0]  point_count_shadow = 8'd0;

   point_req_type pending_reqs[$];
   logic [7:0]  expected_counts[$];
   point_req_type offered;
   int          cycle_count = 0;
   int          reqs_accepted = 0;
   int          results_seen = 0;
   int          failures = 0;
   int          idle_cycles = 0;
   int          settings_used = 0;
   bit          stall_request = 1'b0;
   bit          stall_done = 1'b0;
   int          stall_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
         return 1'b0;
      return $urandom_range(0, 99) < 12;
   endfunction

   // Maximum matching by depth-first augmenting paths, one search per red point.
   function automatic int max_pairs(int n);
      int  partner [SLOTS];
      bit  paired [SLOTS];
      bit  seen [SLOTS];
      int  stack_red [SLOTS];
      int  stack_next [SLOTS];
      int  depth;
      int  total;
      int  u;
      int  j;
      bit  found;
      total = 0;
      for (int b = 0; b < SLOTS; b++) begin
         paired[b] = 1'b0;
         partner[b] = 0;
      end
      for (int r = 0; r < n; r++) begin
         for (int b = 0; b < SLOTS; b++) seen[b] = 1'b0;
         stack_red[0] = r;
         stack_next[0] = 0;
         depth = 1;
         found = 1'b0;
         while (depth > 0 && !found) begin
            u = stack_red[depth - 1];
            j = stack_next[depth - 1];
            while (j < n && (seen[j] || !(red_x[u] < blue_x[j] && red_y[u] < blue_y[j])))
               j++;
            if (j >= n) begin
               depth--;
            end else begin
               stack_next[depth - 1] = j + 1;
               seen[j] = 1'b1;
               if (!paired[j]) begin
                  // Flip the whole path so every red on the stack takes its new blue.
                  for (int k = 0; k < depth; k++) begin
                     partner[stack_next[k] - 1] = stack_red[k];
                     paired[stack_next[k] - 1] = 1'b1;
                  end
                  found = 1'b1;
               end else if (depth < SLOTS) begin
                  stack_red[depth] = partner[j];
                  stack_next[depth] = 0;
                  depth++;
               end
            end
         end
         if (found) total++;
      end
      return total;
   endfunction

   function automatic void apply_request(point_req_type item);
      int n;
      int c;
      case (item.cmd)
         CMD_LOAD_RED: begin
            red_x[item.slot] = item.x;
            red_y[item.slot] = item.y;
         end
         CMD_LOAD_BLUE: begin
            blue_x[item.slot] = item.x;
            blue_y[item.slot] = item.y;
         end
         CMD_COMPUTE: begin
            n = (point_count_shadow > SLOTS) ? SLOTS : int'(point_count_shadow);
            c = max_pairs(n);
            expected_counts.insert(expected_counts.size(), (c > 255) ? 8'd255 : c[7:0]);
         end
         default: ;
      endcase
   endfunction

   // Request driver: the predictor sees each request at its transfer.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_request(offered);
            reqs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && !take_break()) begin
               offered = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= offered.cmd;
               req_point_index <= offered.slot;
               req_coord_x <= offered.x;
               req_coord_y <= offered.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor, which also owns the receiver's back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
               $display("%0t: result with nothing pending, pair_count %0d",
                        $realtime, rsp_pair_count);
               failures++;
            end else begin
               logic [7:0] want;
               want = expected_counts.pop_front();
               if (rsp_pair_count !== want) begin
                  $display("%0t: pair_count expected %0d, got %0d",
                           $realtime, want, rsp_pair_count);
                  failures++;
               end
            end
         end
         if (stall_request && !stall_done) begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !take_break();
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
         $display("[dominance_bipartite_matching] ERROR");
         $finish;
      end
   end

   // Stimulus side.
   bit red_written [SLOTS];
   bit blue_written [SLOTS];
   int reqs_queued = 0;

   task automatic queue_req(logic [1:0] cmd, int slot, logic [15:0] x, logic [15:0] y);
      point_req_type item;
      item.cmd = cmd;
      item.slot = slot[6:0];
      item.x = x;
      item.y = y;
      if (cmd == CMD_LOAD_RED) red_written[slot] = 1'b1;
      if (cmd == CMD_LOAD_BLUE) blue_written[slot] = 1'b1;
      pending_reqs.insert(pending_reqs.size(), item);
      reqs_queued++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_counts.size() != 0);
      // Loads have no result, so give a trailing load time to settle.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      point_count_shadow = value;
      settings_used++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 1))
         return 16'($urandom_range(0, 15));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_phase(int count);
      int n;
      int rounds;
      int slot;
      n = (count > SLOTS) ? SLOTS : count;
      for (int i = 0; i < n; i++) begin
         if (!red_written[i]) queue_req(CMD_LOAD_RED, i, pick_coord(), pick_coord());
         if (!blue_written[i]) queue_req(CMD_LOAD_BLUE, i, pick_coord(), pick_coord());
      end
      // During the long receiver stall several computes back up behind the result.
      if (stall_request && !stall_done)
         rounds = $urandom_range(3, 4);
      else
         rounds = $urandom_range(1, 4);
      for (int r = 0; r < rounds; r++) begin
         for (int k = $urandom_range(0, 2 * n + 3); k > 0; k--) begin
            if ($urandom_range(0, 9) == 0 || n == 0)
               slot = $urandom_range(0, SLOTS - 1);
            else
               slot = $urandom_range(0, n - 1);
            if ($urandom_range(0, 19) == 0)
               queue_req(CMD_RESERVED, $urandom_range(0, SLOTS - 1), pick_coord(),
                         pick_coord());
            else
               queue_req($urandom_range(0, 1) ? CMD_LOAD_BLUE : CMD_LOAD_RED,
                         slot, pick_coord(), pick_coord());
         end
         queue_req(CMD_COMPUTE, $urandom_range(0, SLOTS - 1), pick_coord(), pick_coord());
      end
   endtask

   initial begin
      int pick;
      int count;
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, ignored command, extreme coordinates and ties.
      set_point_count(8'd0);
      queue_req(CMD_COMPUTE, 0, 16'd0, 16'd0);
      queue_req(CMD_RESERVED, 127, 16'hFFFF, 16'hFFFF);
      wait_drained();
      set_point_count(8'd4);
      queue_req(CMD_LOAD_RED, 0, 16'd0, 16'd0);
      queue_req(CMD_LOAD_RED, 1, 16'd5, 16'd5);
      queue_req(CMD_LOAD_RED, 2, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_LOAD_RED, 3, 16'd0, 16'd9);
      queue_req(CMD_LOAD_BLUE, 0, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_LOAD_BLUE, 1, 16'd5, 16'd6);
      queue_req(CMD_LOAD_BLUE, 2, 16'd6, 16'd6);
      queue_req(CMD_LOAD_BLUE, 3, 16'd1, 16'd1);
      queue_req(CMD_COMPUTE, 0, 16'd0, 16'd0);
      queue_req(CMD_LOAD_RED, 127, 16'hFFFF, 16'h0000);
      queue_req(CMD_LOAD_BLUE, 127, 16'h0000, 16'hFFFF);
      queue_req(CMD_LOAD_BLUE, 3, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_COMPUTE, 127, 16'hFFFF, 16'hFFFF);
      wait_drained();
      set_point_count(8'd1);
      queue_req(CMD_COMPUTE, 0, 16'd0, 16'd0);
      wait_drained();

      // Random: first the saturating count with every slot filled, then mostly small sets.
      phase = 0;
      while (reqs_queued < 1900) begin
         if (phase == 0) begin
            count = 255;
         end else if (phase == 2) begin
            count = $urandom_range(2, 6);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) count = 128;
            else if (pick < 4) count = $urandom_range(129, 255);
            else if (pick < 8) count = 0;
            else count = $urandom_range(1, 12);
         end
         set_point_count(count[7:0]);
         if (phase == 2) stall_request = 1'b1;
         random_phase(count);
         wait_drained();
         phase++;
      end

      $display("Run covered %0d requests and %0d pair counts over %0d point_count settings.",
               reqs_accepted, results_seen, settings_used);
      if (failures == 0)
         $display("[dominance_bipartite_matching] OK");
      else
         $display("[dominance_bipartite_matching] ERROR");
      $finish;
   end

endmodule
